[rtl/tbp_pkg.sv]
// Shared types, constants and helper functions for the TAGE branch predictor.
// Depends on nothing; tbp_front, tbp_back and the top level use it by scoped names.
package tbp_pkg;

   // Default sizes of the history and the tables.
   localparam int HISTORY_BITS_DEF  = 1728;
   localparam int BASE_ENTRIES_DEF  = 16384;
   localparam int T1_INDEX_BITS_DEF = 12;
   localparam int T2_INDEX_BITS_DEF = 13;
   localparam int T3_INDEX_BITS_DEF = 12;
   localparam int T4_INDEX_BITS_DEF = 10;

   // Fixed per-table tag widths and the history lengths of the first three tables.
   localparam int NUM_TABLES = 4;
   localparam int TAG_WIDTHS [NUM_TABLES] = '{8, 11, 13, 14};
   localparam int HIST_LENS  [NUM_TABLES - 1] = '{8, 48, 288};
   localparam int TAG_MAX_W  = 14;
   localparam int IDX_MAX_W  = 16;

   // Counter constants.
   localparam logic [2:0] CTR_MAX  = 3'd7;
   localparam logic [2:0] CTR_WEAK = 3'd3;
   localparam logic [2:0] ALT_MAX  = 3'd7;
   localparam logic [2:0] ALT_THRESHOLD = 3'd3;

   // Item kinds.
   localparam logic ACT_PREDICT = 1'b0;
   localparam logic ACT_UPDATE  = 1'b1;

   // Sequencer states of the back end.
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_HASH  = 5'b00100,
      ST_READ  = 5'b01000,
      ST_EVAL  = 5'b10000
   } state_type;

   // One input word as it waits in the queue.
   typedef struct packed {
      logic        action;
      logic [31:0] pc;
      logic        taken;
      logic        predicted_taken;
   } item_type;

   // Saturating step of a 3-bit counter.
   function automatic logic [2:0] ctr_step(input logic [2:0] c, input logic up);
      logic [2:0] r;
      r = c;
      if (up) begin
         if (c < CTR_MAX) r = c + 3'd1;
      end else begin
         if (c != 3'd0) r = c - 3'd1;
      end
      return r;
   endfunction

   function automatic int max2(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

[rtl/tbp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/tbp_fold.sv]
// Folded-history hash: XOR of fixed history taps into a W-bit value, then XOR with pc.
// Depends on nothing.
module tbp_fold #(
   parameter int LEN       = 8,
   parameter int W         = 8,
   parameter int HIST_BITS = 1728
) (
   input  logic [HIST_BITS-1:0] hist,
   input  logic [W-1:0]         pc,
   output logic [W-1:0]         hash
);

   localparam int N    = (LEN + 1) / 2;
   localparam int HALF = W / 2;

   logic [W-1:0] fold;

   // Each history tap lands at a fixed bit of the folded value, so the fold
   // is a set of independent parity trees.
   always_comb begin
      fold = '0;
      for (int k = 0; k < N; k++) begin
         if (k < HIST_BITS) begin
            fold[(N - 1 - k) % W] = fold[(N - 1 - k) % W] ^ hist[k];
         end
         if (LEN - 1 - k < HIST_BITS) begin
            fold[(HALF + N - 1 - k) % W] = fold[(HALF + N - 1 - k) % W] ^ hist[LEN - 1 - k];
         end
      end
   end

   assign hash = fold ^ pc;

endmodule

[rtl/tbp_front.sv]
// Front end: accepts request words into a two-entry queue for the back end.
// Depends on tbp_pkg.
module tbp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tbp_pkg::item_type in_item,
   output logic              q_valid,
   input  logic              q_pop,
   output tbp_pkg::item_type q_item
);

   tbp_pkg::item_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];

   // Pointer and fill count.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[rtl/tbp_back.sv]
// Back end: table memories, hashing, prediction and training sequencer.
// Depends on tbp_pkg, tbp_ram and tbp_fold.
module tbp_back #(
   parameter int HISTORY_BITS  = tbp_pkg::HISTORY_BITS_DEF,
   parameter int BASE_ENTRIES  = tbp_pkg::BASE_ENTRIES_DEF,
   parameter int T1_INDEX_BITS = tbp_pkg::T1_INDEX_BITS_DEF,
   parameter int T2_INDEX_BITS = tbp_pkg::T2_INDEX_BITS_DEF,
   parameter int T3_INDEX_BITS = tbp_pkg::T3_INDEX_BITS_DEF,
   parameter int T4_INDEX_BITS = tbp_pkg::T4_INDEX_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  tbp_pkg::item_type q_item,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_prediction
);

   // Base table is indexed by the low pc bits; its size must be a power of two, which the block does not check.
   localparam int BASE_W  = $clog2(BASE_ENTRIES);
   localparam int ENTRY_W = tbp_pkg::max2(BASE_W, tbp_pkg::max2(
      tbp_pkg::max2(T1_INDEX_BITS, T2_INDEX_BITS), tbp_pkg::max2(T3_INDEX_BITS, T4_INDEX_BITS)));
   localparam int CLR_DEPTH = tbp_pkg::max2(BASE_ENTRIES, 1 << ENTRY_W);
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);
   localparam int NT = tbp_pkg::NUM_TABLES;

   tbp_pkg::state_type state_ff, state_in;
   tbp_pkg::item_type  item_ff;
   logic [CLR_W-1:0]   clr_ff, clr_in;
   logic [HISTORY_BITS-1:0] history_ff;
   logic [2:0]         uac_ff, uac_in;
   logic [2:0]         prov_ff, prov_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic               ppred_ff, ppred_in;
   logic               apred_ff, apred_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_pred_ff, out_pred_in;

   // Per-table views.
   logic [tbp_pkg::IDX_MAX_W-1:0] idx_h [NT];
   logic [tbp_pkg::TAG_MAX_W-1:0] tag_h [NT];
   logic [tbp_pkg::IDX_MAX_W-1:0] idx_ff [NT];
   logic [tbp_pkg::TAG_MAX_W-1:0] tag_ff [NT];
   logic [2:0]                    rd_ctr [NT];
   logic                          rd_u   [NT];
   logic [tbp_pkg::TAG_MAX_W-1:0] rd_tag [NT];
   logic                          hit    [NT];
   logic                          wr_en  [NT];
   logic [2:0]                    wr_ctr [NT];
   logic                          wr_u   [NT];
   logic [tbp_pkg::TAG_MAX_W-1:0] wr_tag [NT];

   logic             is_upd;
   logic             eval_go;
   logic             clearing;
   logic [BASE_W-1:0] base_raddr;
   logic [2:0]       base_rd;
   logic [2:0]       base_wr;
   logic             base_we;

   // Lookup results of a predict word.
   logic             p_found, p_alt_found, p_ppred, p_apred, p_unull;
   logic [2:0]       p_prov;
   logic [tbp_pkg::IDX_MAX_W-1:0] p_idx;
   logic             base_pred;

   // Training decisions of an update word.
   logic             prov_tagged, mispred, alt_right, alloc_done;

   assign is_upd   = (item_ff.action == tbp_pkg::ACT_UPDATE);
   assign clearing = (state_ff == tbp_pkg::ST_CLEAR);
   assign eval_go  = (state_ff == tbp_pkg::ST_EVAL) &&
                     !(!is_upd && out_valid_ff && !out_ready);
   assign q_pop    = (state_ff == tbp_pkg::ST_IDLE) && q_valid;

   // Tagged tables: hashes, memory and entry unpacking.
   for (genvar g = 0; g < NT; g++) begin : g_tab
      localparam int IW = (g == 0) ? T1_INDEX_BITS : (g == 1) ? T2_INDEX_BITS :
                          (g == 2) ? T3_INDEX_BITS : T4_INDEX_BITS;
      localparam int TW = tbp_pkg::TAG_WIDTHS[g];
      localparam int HL = (g == NT - 1) ? HISTORY_BITS
                                        : tbp_pkg::HIST_LENS[(g < NT - 1) ? g : 0];
      localparam int EW = TW + 4;

      logic [IW-1:0] idx_raw;
      logic [TW-1:0] tag_raw;
      logic [IW-1:0] raddr;
      logic [IW-1:0] waddr;
      logic [EW-1:0] rdata;
      logic [EW-1:0] wdata;
      logic          we;

      tbp_fold #(.LEN(HL), .W(IW), .HIST_BITS(HISTORY_BITS)) u_fold_idx (
         .hist (history_ff),
         .pc   (item_ff.pc[IW-1:0]),
         .hash (idx_raw)
      );

      tbp_fold #(.LEN(HL), .W(TW), .HIST_BITS(HISTORY_BITS)) u_fold_tag (
         .hist (history_ff),
         .pc   (item_ff.pc[TW-1:0]),
         .hash (tag_raw)
      );

      assign idx_h[g] = tbp_pkg::IDX_MAX_W'(idx_raw);
      assign tag_h[g] = tbp_pkg::TAG_MAX_W'(tag_raw);

      // An update reads the latched provider entry, everything else the hashed slot.
      assign raddr = (is_upd && prov_ff == 3'(g + 1)) ? IW'(entry_ff) : idx_ff[g][IW-1:0];
      assign waddr = clearing ? clr_ff[IW-1:0] : raddr;
      assign we    = clearing || (eval_go && is_upd && wr_en[g]);
      assign wdata = clearing ? {{TW{1'b1}}, 1'b0, tbp_pkg::CTR_WEAK}
                              : {wr_tag[g][TW-1:0], wr_u[g], wr_ctr[g]};

      tbp_ram #(.WIDTH(EW), .DEPTH(1 << IW)) u_ram (
         .clock (clock),
         .we    (we),
         .waddr (waddr),
         .wdata (wdata),
         .raddr (raddr),
         .rdata (rdata)
      );

      assign rd_ctr[g] = rdata[2:0];
      assign rd_u[g]   = rdata[3];
      assign rd_tag[g] = tbp_pkg::TAG_MAX_W'(rdata[EW-1:4]);
      assign hit[g]    = (rd_tag[g] == tag_ff[g]);
   end

   // Base table.
   assign base_raddr = is_upd ? entry_ff[BASE_W-1:0] : item_ff.pc[BASE_W-1:0];
   assign base_wr    = tbp_pkg::ctr_step(base_rd, item_ff.taken);
   assign base_we    = clearing || (eval_go && is_upd && !prov_tagged);

   tbp_ram #(.WIDTH(3), .DEPTH(BASE_ENTRIES)) u_base_ram (
      .clock (clock),
      .we    (base_we),
      .waddr (clearing ? clr_ff[BASE_W-1:0] : base_raddr),
      .wdata (clearing ? tbp_pkg::CTR_WEAK : base_wr),
      .raddr (base_raddr),
      .rdata (base_rd)
   );

   assign base_pred = (base_rd > tbp_pkg::CTR_WEAK);

   // Provider and alternate search, longest history first.
   always_comb begin
      p_found     = 1'b0;
      p_alt_found = 1'b0;
      p_ppred     = 1'b0;
      p_apred     = 1'b0;
      p_unull     = 1'b0;
      p_prov      = 3'd0;
      p_idx       = '0;
      for (int t = NT - 1; t >= 0; t--) begin
         if (hit[t]) begin
            if (!p_found) begin
               p_found = 1'b1;
               p_prov  = 3'(t + 1);
               p_ppred = (rd_ctr[t] > tbp_pkg::CTR_WEAK);
               p_unull = !rd_u[t];
               p_idx   = idx_ff[t];
            end else if (!p_alt_found) begin
               p_alt_found = 1'b1;
               p_apred     = (rd_ctr[t] > tbp_pkg::CTR_WEAK);
            end
         end
      end
      if (!p_found) begin
         p_ppred = base_pred;
      end
      if (!p_alt_found) begin
         p_apred = base_pred;
      end
   end

   // Training: provider counter and useful bit, then allocation above the provider.
   assign prov_tagged = (prov_ff != 3'd0);
   assign mispred     = (item_ff.taken != item_ff.predicted_taken);
   assign alt_right   = (apred_ff == item_ff.taken);

   always_comb begin
      alloc_done = 1'b0;
      for (int t = 0; t < NT; t++) begin
         wr_en[t]  = 1'b0;
         wr_ctr[t] = rd_ctr[t];
         wr_u[t]   = rd_u[t];
         wr_tag[t] = rd_tag[t];
         if (prov_ff == 3'(t + 1)) begin
            wr_en[t]  = 1'b1;
            wr_ctr[t] = tbp_pkg::ctr_step(rd_ctr[t], item_ff.taken);
            if (apred_ff != ppred_ff) begin
               wr_u[t] = !alt_right;
            end
         end else if (mispred && !alloc_done && !(prov_tagged && prov_ff > 3'(t))) begin
            wr_en[t] = 1'b1;
            wr_u[t]  = 1'b0;
            if (!rd_u[t]) begin
               wr_ctr[t]  = tbp_pkg::CTR_WEAK;
               wr_tag[t]  = tag_ff[t];
               alloc_done = 1'b1;
            end
         end
      end
   end

   // Sequencer and latched predictor state.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      uac_in       = uac_ff;
      prov_in      = prov_ff;
      entry_in     = entry_ff;
      ppred_in     = ppred_ff;
      apred_in     = apred_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_pred_in  = out_pred_ff;
      case (state_ff)
         tbp_pkg::ST_CLEAR: begin
            clr_in = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = tbp_pkg::ST_IDLE;
            end
         end
         tbp_pkg::ST_IDLE: begin
            if (q_valid) begin
               state_in = tbp_pkg::ST_HASH;
            end
         end
         tbp_pkg::ST_HASH: begin
            state_in = tbp_pkg::ST_READ;
         end
         tbp_pkg::ST_READ: begin
            state_in = tbp_pkg::ST_EVAL;
         end
         tbp_pkg::ST_EVAL: begin
            if (eval_go) begin
               state_in = tbp_pkg::ST_IDLE;
               if (is_upd) begin
                  if (apred_ff != ppred_ff) begin
                     if (alt_right) begin
                        if (uac_ff < tbp_pkg::ALT_MAX) uac_in = uac_ff + 3'd1;
                     end else begin
                        if (uac_ff != 3'd0) uac_in = uac_ff - 3'd1;
                     end
                  end
               end else begin
                  prov_in      = p_prov;
                  entry_in     = p_found ? ENTRY_W'(p_idx) : ENTRY_W'(item_ff.pc[BASE_W-1:0]);
                  ppred_in     = p_ppred;
                  apred_in     = p_apred;
                  out_valid_in = 1'b1;
                  out_pred_in  = (p_found && p_unull && uac_ff > tbp_pkg::ALT_THRESHOLD)
                                 ? p_apred : p_ppred;
               end
            end
         end
         default: begin
            state_in = tbp_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbp_pkg::ST_CLEAR;
         clr_ff       <= '0;
         history_ff   <= '0;
         uac_ff       <= 3'd0;
         prov_ff      <= 3'd0;
         entry_ff     <= '0;
         ppred_ff     <= 1'b0;
         apred_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         uac_ff       <= uac_in;
         prov_ff      <= prov_in;
         entry_ff     <= entry_in;
         ppred_ff     <= ppred_in;
         apred_ff     <= apred_in;
         out_valid_ff <= out_valid_in;
         if (eval_go && is_upd) begin
            history_ff <= {history_ff[HISTORY_BITS-2:0], item_ff.taken};
         end
      end
   end

   // Payload registers: current word, hashes and result.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (state_ff == tbp_pkg::ST_HASH) begin
         idx_ff <= idx_h;
         tag_ff <= tag_h;
      end
      out_pred_ff <= out_pred_in;
   end

   assign out_valid      = out_valid_ff;
   assign out_prediction = out_pred_ff;

endmodule

[rtl/tage_branch_predictor_top.sv]
// TAGE branch predictor: after reset the block makes one clearing pass over
// max(BASE_ENTRIES, largest tagged table) entries (16384 with the defaults),
// writing reset values into every table, accepting words into its queue but
// processing none. Afterwards the back end takes each word through four steps
// (dequeue, hash, table read, evaluate and write back), the table read step
// set by the registered memory read that lookup and training must pass through.
// A predict word gives one response word; an update word gives none.
// Depends on tbp_pkg, tbp_front and tbp_back.
module tage_branch_predictor_top #(
   parameter int HISTORY_BITS  = tbp_pkg::HISTORY_BITS_DEF,
   parameter int BASE_ENTRIES  = tbp_pkg::BASE_ENTRIES_DEF,
   parameter int T1_INDEX_BITS = tbp_pkg::T1_INDEX_BITS_DEF,
   parameter int T2_INDEX_BITS = tbp_pkg::T2_INDEX_BITS_DEF,
   parameter int T3_INDEX_BITS = tbp_pkg::T3_INDEX_BITS_DEF,
   parameter int T4_INDEX_BITS = tbp_pkg::T4_INDEX_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // pc[31:0], taken[32], predicted_taken[33], zeros
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // prediction[0], zeros
);

   tbp_pkg::item_type in_item;
   tbp_pkg::item_type q_item;
   logic              q_valid;
   logic              q_pop;
   logic              prediction;

   assign in_item.action          = req_tuser;
   assign in_item.pc              = req_tdata[31:0];
   assign in_item.taken           = req_tdata[32];
   assign in_item.predicted_taken = req_tdata[33];

   tbp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_item   (q_item)
   );

   tbp_back #(
      .HISTORY_BITS  (HISTORY_BITS),
      .BASE_ENTRIES  (BASE_ENTRIES),
      .T1_INDEX_BITS (T1_INDEX_BITS),
      .T2_INDEX_BITS (T2_INDEX_BITS),
      .T3_INDEX_BITS (T3_INDEX_BITS),
      .T4_INDEX_BITS (T4_INDEX_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_item         (q_item),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_prediction (prediction)
   );

   assign rsp_tdata = {7'd0, prediction};

endmodule

[rtl/tbp_checker.sv]
// Port-level checks on the predictor's response channel, bound to the top level.
// Depends on tage_branch_predictor_top.
module tbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // Reset leaves no response pending.
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Padding bits of a response word are zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'd0)
      else $error("response padding not zero");

endmodule

bind tage_branch_predictor_top tbp_checker u_tbp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
